/* rtl/core/assert_macros.svh */
// ---------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers shared by the splitter modules
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge outside reset
`define PBS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked on every rising edge, reset included
`define PBS_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

/* rtl/core/pbs_pkg.sv */
// ---------------------------------------------------------------------------
// pbs_pkg
// widths, constants and controller/datapath signal groups of the splitter
// ---------------------------------------------------------------------------
package pbs_pkg;

  localparam int ADDR_W     = 48;
  localparam int LEN_W      = 27;
  localparam int CFG_DATA_W = 64;
  localparam int PADDR_W    = 4;

  localparam int PAGE_BYTES = 2097152;
  localparam int PAGE_W     = $clog2(PAGE_BYTES);
  localparam int LEN_LIMIT  = 67108864;
  localparam int MAX_PIECES = 33;
  localparam int CNT_W      = $clog2(MAX_PIECES + 1);

  // register index, taken from paddr[3]
  localparam logic REG_BASE_VADDR = 1'b0;

  // controller to datapath
  typedef struct packed {
    logic load_single;  // command fits its page, pass it through
    logic load_first;   // first piece of a split command
    logic emit_page;    // whole middle page
    logic emit_last;    // remainder piece
  } pbs_ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic cmd_fits;     // offset plus length stays inside the page
    logic cmd_bad;      // length above the legal range
    logic more_pages;   // more than a page still pending, piece cap not reached
    logic out_free;     // piece register empty or being taken
  } pbs_stat_t;

endpackage

/* rtl/core/pbs_intf.sv */
// ---------------------------------------------------------------------------
// pbs_intf
// valid/ready channels for write commands and emitted pieces
// ---------------------------------------------------------------------------
interface pbs_cmd_if
  import pbs_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] cmd_addr;
  logic [LEN_W-1:0]  cmd_len;

  modport source (output valid, cmd_addr, cmd_len, input ready);
  modport sink   (input valid, cmd_addr, cmd_len, output ready);
endinterface

interface pbs_piece_if
  import pbs_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] piece_addr;
  logic [LEN_W-1:0]  piece_len;
  logic              piece_last;

  modport source (output valid, piece_addr, piece_len, piece_last, input ready);
  modport sink   (input valid, piece_addr, piece_len, piece_last, output ready);
endinterface

/* rtl/core/pbs_ctrl.sv */
// ---------------------------------------------------------------------------
// pbs_ctrl
// state machine sequencing pass-through and split requests
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module pbs_ctrl
  import pbs_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cmd_valid_i,
  output logic      cmd_ready_o,
  input  pbs_stat_t stat_i,
  output pbs_ctrl_t ctrl_o
);

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_SPLIT = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign cmd_ready_o = (state_q == ST_IDLE) && stat_i.out_free;
  assign accept      = cmd_valid_i && cmd_ready_o;

  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && !stat_i.cmd_bad) begin
          if (stat_i.cmd_fits) begin
            ctrl_o.load_single = 1'b1;
          end else begin
            ctrl_o.load_first = 1'b1;
            state_d           = ST_SPLIT;
          end
        end
      end
      ST_SPLIT: begin
        if (stat_i.out_free) begin
          if (stat_i.more_pages) begin
            ctrl_o.emit_page = 1'b1;
          end else begin
            ctrl_o.emit_last = 1'b1;
            state_d          = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `PBS_ASSERT(a_one_cmd_at_a_time, $onehot0(ctrl_o), "more than one datapath command")
  `PBS_ASSERT(a_split_ends_idle, ctrl_o.emit_last |=> state_q == ST_IDLE && cmd_ready_o == stat_i.out_free, "split did not return to idle")
  `PBS_ASSERT(a_no_accept_in_split, state_q == ST_SPLIT |-> !(cmd_valid_i && cmd_ready_o), "request taken while splitting")

endmodule

/* rtl/core/pbs_dpath.sv */
// ---------------------------------------------------------------------------
// pbs_dpath
// page offset arithmetic, pending remainder and piece output register
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module pbs_dpath
  import pbs_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [ADDR_W-1:0] cmd_addr_i,
  input  logic [LEN_W-1:0]  cmd_len_i,
  input  logic [ADDR_W-1:0] base_vaddr_i,
  input  pbs_ctrl_t         ctrl_i,
  output pbs_stat_t         stat_o,
  output logic              piece_valid_o,
  input  logic              piece_ready_i,
  output logic [ADDR_W-1:0] piece_addr_o,
  output logic [LEN_W-1:0]  piece_len_o,
  output logic              piece_last_o
);

  logic [PAGE_W-1:0] offset;
  logic [LEN_W-1:0]  first_len;
  logic [LEN_W:0]    end_sum;

  logic              out_valid_q, out_valid_d;
  logic [ADDR_W-1:0] out_addr_q, out_addr_d;
  logic [LEN_W-1:0]  out_len_q, out_len_d;
  logic              out_last_q, out_last_d;
  logic [ADDR_W-1:0] pend_addr_q, pend_addr_d;
  logic [LEN_W-1:0]  pend_len_q, pend_len_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;

  // only the low page bits of (addr - base) matter
  assign offset    = cmd_addr_i[PAGE_W-1:0] - base_vaddr_i[PAGE_W-1:0];
  assign first_len = LEN_W'(PAGE_BYTES) - LEN_W'(offset);
  assign end_sum   = {1'b0, cmd_len_i} + (LEN_W+1)'(offset);

  assign stat_o.cmd_fits   = end_sum <= (LEN_W+1)'(PAGE_BYTES);
  assign stat_o.cmd_bad    = cmd_len_i > LEN_W'(LEN_LIMIT);
  assign stat_o.more_pages = (pend_len_q > LEN_W'(PAGE_BYTES))
                          && (cnt_q < CNT_W'(MAX_PIECES - 1));
  assign stat_o.out_free   = !out_valid_q || piece_ready_i;

  always_comb begin
    out_addr_d  = out_addr_q;
    out_len_d   = out_len_q;
    out_last_d  = out_last_q;
    pend_addr_d = pend_addr_q;
    pend_len_d  = pend_len_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !piece_ready_i;
    if (ctrl_i.load_single) begin
      out_addr_d  = cmd_addr_i;
      out_len_d   = cmd_len_i;
      out_last_d  = 1'b1;
      out_valid_d = 1'b1;
    end
    if (ctrl_i.load_first) begin
      out_addr_d  = cmd_addr_i;
      out_len_d   = first_len;
      out_last_d  = 1'b0;
      out_valid_d = 1'b1;
      pend_addr_d = cmd_addr_i + ADDR_W'(first_len);
      pend_len_d  = cmd_len_i - first_len;
      cnt_d       = CNT_W'(1);
    end
    if (ctrl_i.emit_page) begin
      out_addr_d  = pend_addr_q;
      out_len_d   = LEN_W'(PAGE_BYTES);
      out_last_d  = 1'b0;
      out_valid_d = 1'b1;
      pend_addr_d = pend_addr_q + ADDR_W'(PAGE_BYTES);
      pend_len_d  = pend_len_q - LEN_W'(PAGE_BYTES);
      cnt_d       = cnt_q + CNT_W'(1);
    end
    if (ctrl_i.emit_last) begin
      out_addr_d  = pend_addr_q;
      out_len_d   = pend_len_q;
      out_last_d  = 1'b1;
      out_valid_d = 1'b1;
      cnt_d       = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_addr_q  <= out_addr_d;
    out_len_q   <= out_len_d;
    out_last_q  <= out_last_d;
    pend_addr_q <= pend_addr_d;
    pend_len_q  <= pend_len_d;
  end

  assign piece_valid_o = out_valid_q;
  assign piece_addr_o  = out_addr_q;
  assign piece_len_o   = out_len_q;
  assign piece_last_o  = out_last_q;

  `PBS_ASSERT(a_cnt_bounded, cnt_q <= CNT_W'(MAX_PIECES), "piece count over limit")
  `PBS_ASSERT(a_inner_piece_len, out_valid_q && !out_last_q |-> out_len_q <= LEN_W'(PAGE_BYTES) && out_len_q != '0, "inner piece length out of page")

endmodule

/* rtl/core/page_boundary_command_splitter.sv */
// ---------------------------------------------------------------------------
// page_boundary_command_splitter
// splits write requests so that no piece crosses a page boundary
// ---------------------------------------------------------------------------
//
//   channel   dir  handshake        payload
//   cmd_i     in   valid / ready    cmd_addr[47:0], cmd_len[26:0]
//   piece_o   out  valid / ready    piece_addr[47:0], piece_len[26:0], piece_last
//   apb       in   psel / penable   paddr[3:0], pwdata[63:0], prdata[63:0]
//
// a request that fits its page is taken and shown in the next cycle; such
//   requests stream at one per cycle while piece_o is ready
// a split request holds cmd_i off until its last piece is loaded: the
//   sequencer drives one piece per cycle into the single piece register
//   while piece_o is ready, and the next request can then be taken
// a request with length above 2^26 is taken and dropped, no piece
// piece_o stalls hold the piece register and, through it, the sequencer
// reset is asynchronous, active low; base_vaddr resets to zero
// ---------------------------------------------------------------------------
module page_boundary_command_splitter
  import pbs_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  pbs_cmd_if.sink               cmd_i,
  pbs_piece_if.source           piece_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_W-1:0]    paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [ADDR_W-1:0] base_vaddr_q;
  logic              reg_we;
  pbs_ctrl_t         ctrl;
  pbs_stat_t         stat;
  logic              cmd_ready;

  // config register, 8-byte slot at offset 0
  assign pready = 1'b1;
  assign reg_we = psel && penable && pwrite && (paddr[3] == REG_BASE_VADDR);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_vaddr_q <= '0;
    end else if (reg_we) begin
      base_vaddr_q <= pwdata[ADDR_W-1:0];
    end
  end

  // unmapped slot reads zero
  assign prdata = (paddr[3] == REG_BASE_VADDR)
                ? CFG_DATA_W'(base_vaddr_q) : '0;

  // sequencer: idle / splitting
  pbs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_i.valid),
    .cmd_ready_o (cmd_ready),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  assign cmd_i.ready = cmd_ready;

  // offset math, pending remainder, piece register
  pbs_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_addr_i    (cmd_i.cmd_addr),
    .cmd_len_i     (cmd_i.cmd_len),
    .base_vaddr_i  (base_vaddr_q),
    .ctrl_i        (ctrl),
    .stat_o        (stat),
    .piece_valid_o (piece_o.valid),
    .piece_ready_i (piece_o.ready),
    .piece_addr_o  (piece_o.piece_addr),
    .piece_len_o   (piece_o.piece_len),
    .piece_last_o  (piece_o.piece_last)
  );

endmodule

/* tb/tb_page_boundary_command_splitter.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_page_boundary_command_splitter
// self-checking bench: random write requests go in through a valid/ready
// driver, every emitted piece is matched in order against a local page split
// predictor, base_vaddr is reprogrammed over apb between phases
// ---------------------------------------------------------------------------
module tb_page_boundary_command_splitter;
  import pbs_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 16;
  localparam int RANDOM_ITEMS = 120;   // per random phase, four phases
  localparam logic [PADDR_W-1:0] BASE_VADDR_PADDR = PADDR_W'(REG_BASE_VADDR) << 3;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [LEN_W-1:0]  len;
  } write_req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [LEN_W-1:0]  len;
    logic              last;
  } piece_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // request side
  logic              cmd_valid = 1'b0;
  logic [ADDR_W-1:0] cmd_addr  = '0;
  logic [LEN_W-1:0]  cmd_len   = '0;
  // piece side
  logic              piece_ready = 1'b0;
  // apb
  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [PADDR_W-1:0]    paddr   = '0;
  logic [CFG_DATA_W-1:0] pwdata  = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  write_req_t        pending_reqs[$];     // requests not yet taken by the splitter
  piece_t            expected_pieces[$];  // pieces predicted, not yet seen
  logic [ADDR_W-1:0] base_vaddr_model = '0;
  bit                bursts_enabled   = 1'b1;
  int                req_gap_left     = 0;
  int                piece_stall_left = 0;
  int                mismatch_count   = 0;
  int                cycle_count      = 0;

  pbs_cmd_if   cmd_if ();
  pbs_piece_if piece_if ();

  assign cmd_if.valid    = cmd_valid;
  assign cmd_if.cmd_addr = cmd_addr;
  assign cmd_if.cmd_len  = cmd_len;
  assign piece_if.ready  = piece_ready;

  page_boundary_command_splitter dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd_if),
    .piece_o (piece_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // page split of one request under the current base_vaddr; oversized
  // lengths are swallowed by the block and give nothing
  function automatic void predict_pieces(input logic [ADDR_W-1:0] addr,
                                         input logic [LEN_W-1:0] len);
    logic [ADDR_W-1:0] rel_addr;
    logic [ADDR_W-1:0] cur_addr;
    longint unsigned   offset;
    longint unsigned   remain;
    longint unsigned   first;
    int                count;
    if (len > LEN_LIMIT) return;
    rel_addr = addr - base_vaddr_model;
    offset   = rel_addr & ADDR_W'(PAGE_BYTES - 1);
    // fits its page, zero length included: passes as is
    if (offset + len <= PAGE_BYTES) begin
      expected_pieces.push_back(piece_t'{addr: addr, len: len, last: 1'b1});
      return;
    end
    first = PAGE_BYTES - offset;
    expected_pieces.push_back(piece_t'{addr: addr, len: first[LEN_W-1:0], last: 1'b0});
    cur_addr = addr + first[ADDR_W-1:0];   // wraps at 2^48
    remain   = len - first;
    count    = 1;
    // whole pages; the piece cap folds whatever is left into the final piece
    while (remain > PAGE_BYTES && count < MAX_PIECES - 1) begin
      expected_pieces.push_back(piece_t'{addr: cur_addr, len: LEN_W'(PAGE_BYTES), last: 1'b0});
      cur_addr = cur_addr + ADDR_W'(PAGE_BYTES);
      remain   = remain - PAGE_BYTES;
      count++;
    end
    expected_pieces.push_back(piece_t'{addr: cur_addr, len: remain[LEN_W-1:0], last: 1'b1});
  endfunction

  // mostly short requests, with page edges, multi-page, maximum and
  // oversized lengths mixed in; addresses are placed relative to the base
  function automatic write_req_t random_request();
    write_req_t        req;
    logic [ADDR_W-1:0] page_start;
    int unsigned       pick;
    int unsigned       gap;
    int unsigned       span;
    pick       = $urandom_range(0, 99);
    page_start = (ADDR_W'({$urandom, $urandom}) & ~ADDR_W'(PAGE_BYTES - 1))
                 + base_vaddr_model;
    req.addr   = page_start + ADDR_W'($urandom_range(0, PAGE_BYTES - 1));
    if (pick < 36) begin
      req.len = LEN_W'($urandom_range(1, 4096));
    end else if (pick < 56) begin
      // a few bytes either side of the page end
      gap      = $urandom_range(0, 64);
      span     = gap + $urandom_range(0, 6);
      req.addr = page_start + ADDR_W'(PAGE_BYTES - gap);
      req.len  = (span >= 3) ? LEN_W'(span - 3) : '0;
    end else if (pick < 76) begin
      req.len = LEN_W'($urandom_range(1, 4 * PAGE_BYTES));
    end else if (pick < 86) begin
      req.len = LEN_W'($urandom) & LEN_W'(LEN_LIMIT - 1);
    end else if (pick < 89) begin
      req.len = LEN_W'(LEN_LIMIT);
    end else if (pick < 92) begin
      req.addr = page_start;
      req.len  = LEN_W'(LEN_LIMIT);
    end else if (pick < 96) begin
      req.len = LEN_W'($urandom_range(LEN_LIMIT + 1, (1 << LEN_W) - 1));
    end else begin
      req.len = '0;
    end
    return req;
  endfunction

  // write base_vaddr while the splitter is idle, then read it back
  task automatic program_base_vaddr(input logic [ADDR_W-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= BASE_VADDR_PADDR;
    pwdata  <= CFG_DATA_W'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    base_vaddr_model = value;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata[ADDR_W-1:0] !== value) begin
      $display("%0t base_vaddr readback: expected %h, actual %h",
               $time, value, prdata[ADDR_W-1:0]);
      mismatch_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // all requests taken, all pieces seen, then a few quiet cycles so that a
  // late or stray piece still shows up
  task automatic wait_drained();
    while (pending_reqs.size() != 0 || cmd_valid || expected_pieces.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic queue_random(input int count);
    for (int i = 0; i < count; i++) pending_reqs.push_back(random_request());
  endtask

  // request driver: valid is held until taken, gaps only between requests
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      cmd_valid <= 1'b0;
    end else begin
      if (cmd_valid && cmd_if.ready) begin
        predict_pieces(cmd_addr, cmd_len);
        void'(pending_reqs.pop_front());
      end
      if (cmd_valid && !cmd_if.ready) begin
        // stalled by the splitter, keep the request on the bus
      end else if (req_gap_left > 0) begin
        req_gap_left--;
        cmd_valid <= 1'b0;
      end else if (pending_reqs.size() == 0) begin
        cmd_valid <= 1'b0;
      end else if (bursts_enabled && $urandom_range(0, 7) == 0) begin
        req_gap_left = $urandom_range(0, 9);
        cmd_valid <= 1'b0;
      end else begin
        cmd_valid <= 1'b1;
        cmd_addr  <= pending_reqs[0].addr;
        cmd_len   <= pending_reqs[0].len;
      end
    end
  end

  // piece monitor: in-order compare, ready dropped in random bursts
  always @(posedge clk_i) begin : piece_monitor
    piece_t want;
    if (!rst_ni) begin
      piece_ready <= 1'b0;
    end else begin
      if (piece_if.valid && piece_ready) begin
        if (expected_pieces.size() == 0) begin
          $display("%0t unexpected piece: expected none, actual addr %h len %0d last %b",
                   $time, piece_if.piece_addr, piece_if.piece_len, piece_if.piece_last);
          mismatch_count++;
        end else begin
          want = expected_pieces.pop_front();
          if (piece_if.piece_addr !== want.addr) begin
            $display("%0t piece_addr: expected %h, actual %h",
                     $time, want.addr, piece_if.piece_addr);
            mismatch_count++;
          end
          if (piece_if.piece_len !== want.len) begin
            $display("%0t piece_len: expected %0d, actual %0d",
                     $time, want.len, piece_if.piece_len);
            mismatch_count++;
          end
          if (piece_if.piece_last !== want.last) begin
            $display("%0t piece_last: expected %b, actual %b",
                     $time, want.last, piece_if.piece_last);
            mismatch_count++;
          end
        end
      end
      if (piece_stall_left > 0) begin
        piece_stall_left--;
        piece_ready <= 1'b0;
      end else if (bursts_enabled && $urandom_range(0, 7) == 0) begin
        piece_stall_left = $urandom_range(0, 9);
        piece_ready <= 1'b0;
      end else begin
        piece_ready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_page_boundary_command_splitter failed");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed requests with base_vaddr at its reset value
    pending_reqs.push_back(write_req_t'{addr: '0, len: '0});               // zero length
    pending_reqs.push_back(write_req_t'{addr: '1, len: '0});               // zero length, top address
    pending_reqs.push_back(write_req_t'{addr: '0, len: LEN_W'(1)});
    pending_reqs.push_back(write_req_t'{addr: '0, len: LEN_W'(PAGE_BYTES)});     // whole page fits
    pending_reqs.push_back(write_req_t'{addr: '0, len: LEN_W'(PAGE_BYTES + 1)}); // one byte over
    pending_reqs.push_back(write_req_t'{addr: ADDR_W'(PAGE_BYTES - 1), len: LEN_W'(1)});
    pending_reqs.push_back(write_req_t'{addr: ADDR_W'(PAGE_BYTES - 1), len: LEN_W'(2)});
    pending_reqs.push_back(write_req_t'{addr: '0, len: LEN_W'(LEN_LIMIT)});      // aligned maximum
    pending_reqs.push_back(write_req_t'{addr: ADDR_W'(PAGE_BYTES - 16),
                                        len: LEN_W'(LEN_LIMIT)});                // most pieces
    pending_reqs.push_back(write_req_t'{addr: '1, len: LEN_W'(LEN_LIMIT)});      // wraps at 2^48
    pending_reqs.push_back(write_req_t'{addr: 48'hFFFF_FFE0_0100,
                                        len: LEN_W'(3 * PAGE_BYTES)});
    pending_reqs.push_back(write_req_t'{addr: 48'h1234_5678_9ABC,
                                        len: LEN_W'(LEN_LIMIT + 1)});            // oversized
    pending_reqs.push_back(write_req_t'{addr: 48'h0000_0000_1000, len: '1});     // oversized, all ones
    pending_reqs.push_back(write_req_t'{addr: 48'hAAAA_AAAA_AAAA, len: 27'h555_5555});
    pending_reqs.push_back(write_req_t'{addr: 48'h5555_5555_5555, len: 27'h2AA_AAAA});
    pending_reqs.push_back(write_req_t'{addr: 48'h0000_001F_FFFF, len: LEN_W'(1)});
    wait_drained();

    // base at its top value: address zero sits one byte into its page
    program_base_vaddr('1);
    pending_reqs.push_back(write_req_t'{addr: '0, len: LEN_W'(PAGE_BYTES)});
    pending_reqs.push_back(write_req_t'{addr: '1, len: LEN_W'(1)});
    queue_random(RANDOM_ITEMS);
    wait_drained();

    program_base_vaddr('0);
    queue_random(RANDOM_ITEMS);
    wait_drained();

    program_base_vaddr(ADDR_W'({$urandom, $urandom}));
    queue_random(RANDOM_ITEMS);
    wait_drained();

    // closing phase at full rate on both sides
    program_base_vaddr(ADDR_W'({$urandom, $urandom}) | ADDR_W'(PAGE_BYTES - 1));
    bursts_enabled = 1'b0;
    queue_random(RANDOM_ITEMS);
    wait_drained();

    if (mismatch_count == 0) begin
      $display("tb_page_boundary_command_splitter passed");
    end else begin
      $display("tb_page_boundary_command_splitter failed");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/pbs_pkg.sv
rtl/core/pbs_intf.sv
rtl/core/pbs_ctrl.sv
rtl/core/pbs_dpath.sv
rtl/core/page_boundary_command_splitter.sv
tb/tb_page_boundary_command_splitter.sv
